FILE: design/dber_pkg.sv
// Shared constants, coefficient table and helper functions for the dual band
// energy ratio probe. Used by every file of the block but dber_ram; depends on nothing.

package dber_pkg;

	// Input format and filter layout
	localparam int SAMPLE_BITS   = 16;
	localparam int HIGH_SECTIONS = 2;
	localparam int BAND_SECTIONS = 3;
	localparam int SECTIONS      = HIGH_SECTIONS + BAND_SECTIONS;
	localparam int SEC_W         = $clog2(SECTIONS);
	localparam int DLY_DEPTH     = 2 * SECTIONS;
	localparam int DLY_AW        = $clog2(DLY_DEPTH);

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;
	localparam int LEAK_W     = 17;
	localparam int EPS_W      = 20;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEAK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_EPS = 1'd1;
	localparam logic [LEAK_W-1:0] LEAK_RESET = 17'd65601;
	localparam logic [EPS_W-1:0]  EPS_RESET  = 20'd1024;

	// Result widths and limits
	localparam int ACC_W   = 40;
	localparam int FLOOR_W = 56;
	localparam int CNT_W   = 32;
	localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
	localparam logic [FLOOR_W-1:0] FLOOR_MAX = {FLOOR_W{1'b1}};
	localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
	localparam logic signed [31:0] DB_PER_LOG2_Q16 = 32'sd197283;

	// Coefficient slots within a section
	localparam int K_B0 = 0;
	localparam int K_B1 = 1;
	localparam int K_B2 = 2;
	localparam int K_A1 = 3;
	localparam int K_A2 = 4;

	// b0, b1, b2, a1, a2 in Q2.30; high-pass sections first, then band sections
	localparam logic signed [31:0] COEF [SECTIONS][5] = '{
		'{ 32'sd374081808, -32'sd748163617, 32'sd374081808,
		  -32'sd353234943, 32'sd69350466 },
		'{ 32'sd515247117, -32'sd1030494236, 32'sd515247117,
		  -32'sd486533380, 32'sd500713267 },
		'{ 32'sd1037111433, -32'sd2074222865, 32'sd1037111433,
		  -32'sd2072972866, 32'sd1001731041 },
		'{ 32'sd30192281, 32'sd60384562, 32'sd30192281,
		  -32'sd1465783472, 32'sd512810774 },
		'{ 32'sd35646548, 32'sd71293097, 32'sd35646548,
		  -32'sd1730578792, 32'sd799423162 }
	};

	// Operands of the shared multiplier
	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
	} mul_req_t;

	// Round a Q2.30 product half up back to Q2.30
	function automatic logic signed [35:0] rnd_q30(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = (p + 64'sd536870912) >>> 30;
		return t[35:0];
	endfunction

	// Clamp to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// Clamp to signed 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		if (v > 40'sd32767)
			return 16'sh7FFF;
		else if (v < -40'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

FILE: design/dber_if.sv
// Valid/ready channel interfaces for the sample input and the frame result.
// Energy and frame count widths come from dber_pkg.

interface dber_smp_if;
	logic                 valid;
	logic                 ready;
	logic signed [15:0]   sample;
	logic                 frame_end;

	modport source (output valid, output sample, output frame_end, input ready);
	modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface dber_res_if;
	logic                                valid;
	logic                                ready;
	logic [dber_pkg::ACC_W-1:0]          energy_high;
	logic [dber_pkg::ACC_W-1:0]          energy_band;
	logic signed [15:0]                  ratio_db;
	logic signed [15:0]                  level_db;
	logic [dber_pkg::CNT_W-1:0]          frames_seen;

	modport source (output valid, output energy_high, output energy_band,
		output ratio_db, output level_db, output frames_seen, input ready);
	modport sink (input valid, input energy_high, input energy_band,
		input ratio_db, input level_db, input frames_seen, output ready);
endinterface

FILE: design/dber_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency.

module dber_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: design/dber_mul.sv
// Shared 32x32 signed multiplier with a registered product.
// Uses dber_pkg::mul_req_t.

module dber_mul (
	input  logic                clk,
	input  dber_pkg::mul_req_t  req,
	output logic signed [63:0]  prod
);

	// Register the product for use in the next cycle
	always_ff @(posedge clk) begin
		prod <= req.a * req.b;
	end

endmodule

FILE: design/dual_band_energy_ratio_probe.sv
// Top level of the dual band energy ratio probe: sequencer, state registers,
// delay RAM and shared multiplier. Depends on dber_pkg, dber_if, dber_ram, dber_mul.
//
//  channel   dir  handshake        payload
//  samples   in   valid/ready      sample[15:0] signed, frame_end
//  results   out  valid/ready      energy_high, energy_band, ratio_db, level_db,
//                                  frames_seen
//  cfg       in   cfg_we           cfg_index[0:0], cfg_data[19:0]
//
// A sample passes through acceptance, the six steps RD0, RD1, A, B, C and D of each of five
// biquad sections through the one multiplier and the delay RAM, and three energy steps.
// A frame end adds the floor steps F0 to F3 (F0 alone when a new minimum is taken), then
// three logs, each normalized one bit a cycle and then refined by 16 squarings.
// Reset clears the control state, accumulators, floor and delay valid bits at once.
// A pending result does not block samples; only a new frame end waits for it.

module dual_band_energy_ratio_probe (
	input  logic                              clk,
	input  logic                              arst_n,
	dber_smp_if.sink                          samples,
	dber_res_if.source                        results,
	input  logic                              cfg_we,
	input  logic [dber_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dber_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_RD0, S_RD1, S_A, S_B, S_C, S_D,
		S_E1, S_E2, S_E3,
		S_F0, S_F1, S_F2, S_F3,
		S_LN, S_NORM, S_SQ, S_SQW,
		S_DB0, S_DB1, S_DB2, S_OUT
	} state_t;

	state_t state_q;

	// Configuration
	logic [dber_pkg::LEAK_W-1:0] leak_q;
	logic [dber_pkg::EPS_W-1:0]  eps_q;

	// Filter datapath
	logic signed [31:0] xin_q, x_q, y_q, yh_q;
	logic signed [35:0] acc_q;
	logic [dber_pkg::SEC_W-1:0] sec_q;
	logic               fe_q;
	logic [dber_pkg::DLY_DEPTH-1:0] dvalid_q;
	logic               rv_q;

	// Frame state
	logic [dber_pkg::ACC_W-1:0]   hacc_q, bacc_q;
	logic [dber_pkg::FLOOR_W-1:0] floor_q;
	logic                         floor_valid_q;
	logic [dber_pkg::CNT_W-1:0]   cnt_q;
	logic [57:0]                  f_q;

	// Log unit
	logic [56:0] v_q;
	logic [5:0]  e_q;
	logic [30:0] m_q;
	logic [21:0] r_q;
	logic [3:0]  bit_q;
	logic [1:0]  lg_q;
	logic [21:0] lv_q [3];
	logic signed [15:0] ratio_q;
	logic signed [15:0] level_q;

	// Output register
	logic                         ov_q;
	logic [dber_pkg::ACC_W-1:0]   oeh_q, oeb_q;
	logic signed [15:0]           ord_q, old_q;
	logic [dber_pkg::CNT_W-1:0]   ofs_q;

	// Shared units
	dber_pkg::mul_req_t      mreq;
	logic signed [63:0]      prod;
	logic                    ram_we;
	logic [dber_pkg::DLY_AW-1:0] ram_waddr, ram_raddr, base, base1;
	logic [31:0]             ram_wdata, ram_rdata;

	dber_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	dber_ram #(
		.WIDTH (32),
		.DEPTH (dber_pkg::DLY_DEPTH)
	) u_dly (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Derived values
	logic signed [31:0] dval, x_in;
	logic signed [35:0] prnd;
	logic [32:0]        sq;
	logic [40:0]        esum;
	logic [55:0]        band16;
	logic [56:0]        larg, larg_nz;
	logic [32:0]        sqt;
	logic [21:0]        r_bit;
	logic signed [22:0] dif0, dif1;
	logic signed [63:0] dbq;
	logic signed [39:0] dbq40;
	logic [57:0]        fsum;

	assign base  = {1'b0, sec_q} << 1;
	assign base1 = base | dber_pkg::DLY_AW'(1);
	assign dval  = rv_q ? $signed(ram_rdata) : 32'sd0;
	assign x_in  = 32'(signed'(samples.sample[dber_pkg::SAMPLE_BITS-1:0]))
		<<< (31 - dber_pkg::SAMPLE_BITS);
	assign prnd  = dber_pkg::rnd_q30(prod);
	assign sq    = 33'((prod[62:0] + 63'd536870912) >> 30);
	assign band16 = {bacc_q, 16'b0};
	assign sqt   = prod[62:30];
	assign r_bit = r_q | (22'd1 << bit_q);
	assign dif0  = $signed({1'b0, lv_q[0]}) - $signed({1'b0, lv_q[1]});
	assign dif1  = $signed({1'b0, lv_q[1]}) - $signed({1'b0, lv_q[2]});
	assign dbq   = (prod + 64'sd8388608) >>> 24;
	assign dbq40 = dbq[39:0];
	assign fsum  = f_q + 58'(prod[32:16]);

	// Pick the energy sum to accumulate and the log argument
	always_comb begin
		esum = (state_q == S_E2) ? ({1'b0, hacc_q} + 41'(sq)) : ({1'b0, bacc_q} + 41'(sq));
		case (lg_q)
			2'd0: larg = 57'({hacc_q, 16'b0}) + 57'({eps_q, 16'b0});
			2'd1: larg = 57'(band16) + 57'({eps_q, 16'b0});
			default: larg = 57'(floor_q) + 57'({eps_q, 16'b0});
		endcase
		larg_nz = (larg == '0) ? 57'd1 : larg;
	end

	// Drive multiplier operands and RAM ports per sequencer step
	always_comb begin
		mreq.a    = '0;
		mreq.b    = '0;
		ram_we    = 1'b0;
		ram_waddr = base;
		ram_wdata = '0;
		ram_raddr = base;
		case (state_q)
			S_RD0: begin
				ram_raddr = base;
				mreq.a = dber_pkg::COEF[sec_q][dber_pkg::K_B0];
				mreq.b = x_q;
			end
			S_RD1: begin
				ram_raddr = base1;
				mreq.a = dber_pkg::COEF[sec_q][dber_pkg::K_B1];
				mreq.b = x_q;
			end
			S_A: begin
				mreq.a = dber_pkg::COEF[sec_q][dber_pkg::K_A1];
				mreq.b = y_q;
			end
			S_B: begin
				ram_we    = 1'b1;
				ram_waddr = base;
				ram_wdata = dber_pkg::sat32(acc_q - prnd);
				mreq.a = dber_pkg::COEF[sec_q][dber_pkg::K_B2];
				mreq.b = x_q;
			end
			S_C: begin
				mreq.a = dber_pkg::COEF[sec_q][dber_pkg::K_A2];
				mreq.b = y_q;
			end
			S_D: begin
				ram_we    = 1'b1;
				ram_waddr = base1;
				ram_wdata = dber_pkg::sat32(acc_q - prnd);
			end
			S_E1: begin
				mreq.a = yh_q;
				mreq.b = yh_q;
			end
			S_E2: begin
				mreq.a = y_q;
				mreq.b = y_q;
			end
			S_F0: begin
				mreq.a = {12'b0, floor_q[35:16]};
				mreq.b = {15'b0, leak_q};
			end
			S_F1: begin
				mreq.a = {12'b0, floor_q[55:36]};
				mreq.b = {15'b0, leak_q};
			end
			S_F2: begin
				mreq.a = {16'b0, floor_q[15:0]};
				mreq.b = {15'b0, leak_q};
			end
			S_SQ: begin
				mreq.a = {1'b0, m_q};
				mreq.b = {1'b0, m_q};
			end
			S_DB0: begin
				mreq.a = 32'(dif0);
				mreq.b = dber_pkg::DB_PER_LOG2_Q16;
			end
			S_DB1: begin
				mreq.a = 32'(dif1);
				mreq.b = dber_pkg::DB_PER_LOG2_Q16;
			end
			default: begin
				mreq.a = '0;
			end
		endcase
	end

	assign samples.ready       = (state_q == S_IDLE);
	assign results.valid       = ov_q;
	assign results.energy_high = oeh_q;
	assign results.energy_band = oeb_q;
	assign results.ratio_db    = ord_q;
	assign results.level_db    = old_q;
	assign results.frames_seen = ofs_q;

	// Sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			leak_q        <= dber_pkg::LEAK_RESET;
			eps_q         <= dber_pkg::EPS_RESET;
			dvalid_q      <= '0;
			rv_q          <= 1'b0;
			hacc_q        <= '0;
			bacc_q        <= '0;
			floor_q       <= '0;
			floor_valid_q <= 1'b0;
			cnt_q         <= '0;
			ov_q          <= 1'b0;
			sec_q         <= '0;
			lg_q          <= '0;
			bit_q         <= '0;
		end else begin
			// Take configuration writes; unknown indexes fall through
			if (cfg_we) begin
				case (cfg_index)
					dber_pkg::REG_FLOOR_LEAK: leak_q <= cfg_data[dber_pkg::LEAK_W-1:0];
					dber_pkg::REG_ENERGY_EPS: eps_q  <= cfg_data[dber_pkg::EPS_W-1:0];
					default: ;
				endcase
			end

			// Track delay entries ever written; unwritten ones read as zero
			rv_q <= dvalid_q[ram_raddr];
			if (ram_we)
				dvalid_q[ram_waddr] <= 1'b1;

			// Drop the result once the transaction completes; S_OUT reloads it itself
			if (ov_q && results.ready && state_q != S_OUT)
				ov_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						xin_q   <= x_in;
						x_q     <= x_in;
						fe_q    <= samples.frame_end;
						sec_q   <= '0;
						state_q <= S_RD0;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					y_q     <= dber_pkg::sat32(prnd + 36'(dval));
					state_q <= S_A;
				end
				S_A: begin
					acc_q   <= prnd + 36'(dval);
					state_q <= S_B;
				end
				S_B: state_q <= S_C;
				S_C: begin
					acc_q   <= prnd;
					state_q <= S_D;
				end
				S_D: begin
					if (sec_q == dber_pkg::SEC_W'(dber_pkg::HIGH_SECTIONS - 1)) begin
						yh_q <= y_q;
						x_q  <= xin_q;
					end else begin
						x_q  <= y_q;
					end
					if (sec_q == dber_pkg::SEC_W'(dber_pkg::SECTIONS - 1)) begin
						state_q <= S_E1;
					end else begin
						sec_q   <= sec_q + 1'b1;
						state_q <= S_RD0;
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: begin
					hacc_q  <= esum[40] ? dber_pkg::ACC_MAX : esum[39:0];
					state_q <= S_E3;
				end
				S_E3: begin
					bacc_q  <= esum[40] ? dber_pkg::ACC_MAX : esum[39:0];
					state_q <= fe_q ? S_F0 : S_IDLE;
				end
				S_F0: begin
					if (cnt_q != dber_pkg::CNT_MAX)
						cnt_q <= cnt_q + 1'b1;
					if (!floor_valid_q || band16 < floor_q) begin
						floor_q       <= band16;
						floor_valid_q <= 1'b1;
						lg_q          <= '0;
						state_q       <= S_LN;
					end else begin
						state_q <= S_F1;
					end
				end
				S_F1: begin
					f_q     <= 58'(prod[36:0]);
					state_q <= S_F2;
				end
				S_F2: begin
					f_q     <= f_q + (58'(prod[36:0]) << 20);
					state_q <= S_F3;
				end
				S_F3: begin
					floor_q <= (fsum > 58'(dber_pkg::FLOOR_MAX)) ? dber_pkg::FLOOR_MAX
						: fsum[55:0];
					lg_q    <= '0;
					state_q <= S_LN;
				end
				S_LN: begin
					v_q     <= larg_nz;
					e_q     <= 6'd30;
					state_q <= S_NORM;
				end
				// Normalize one bit a cycle into [2^30, 2^31)
				S_NORM: begin
					if (v_q[56:31] != '0) begin
						v_q <= v_q >> 1;
						e_q <= e_q + 1'b1;
					end else if (!v_q[30]) begin
						v_q <= v_q << 1;
						e_q <= e_q - 1'b1;
					end else begin
						m_q     <= v_q[30:0];
						r_q     <= {e_q, 16'b0};
						bit_q   <= 4'd15;
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_SQW;
				// One fraction bit per squaring
				S_SQW: begin
					logic [21:0] rn;
					rn = (sqt[32:31] != 2'b00) ? r_bit : r_q;
					m_q <= (sqt[32:31] != 2'b00) ? sqt[31:1] : sqt[30:0];
					r_q <= rn;
					if (bit_q == '0) begin
						lv_q[lg_q] <= rn;
						if (lg_q == 2'd2) begin
							state_q <= S_DB0;
						end else begin
							lg_q    <= lg_q + 1'b1;
							state_q <= S_LN;
						end
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= S_SQ;
					end
				end
				S_DB0: state_q <= S_DB1;
				S_DB1: begin
					ratio_q <= dber_pkg::sat16(dbq40);
					state_q <= S_DB2;
				end
				S_DB2: begin
					level_q <= dber_pkg::sat16(dbq40);
					state_q <= S_OUT;
				end
				// Hold the frame result until the output register is free
				S_OUT: begin
					if (!ov_q || results.ready) begin
						ov_q    <= 1'b1;
						oeh_q   <= hacc_q;
						oeb_q   <= bacc_q;
						ord_q   <= ratio_q;
						old_q   <= level_q;
						ofs_q   <= cnt_q;
						hacc_q  <= '0;
						bacc_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
